FILE: hdl/mfpm_pkg.sv
// Types and constants for the motor fault persistence monitor.
// No dependencies.
package mfpm_pkg;

	localparam int unsigned IDX_W   = 3;
	localparam int unsigned CUR_W   = 16;
	localparam int unsigned TEMP_W  = 12;
	localparam int unsigned POS_W   = 16;
	localparam int unsigned CLIM_W  = 15;
	localparam int unsigned PERS_W  = 8;
	localparam int unsigned MISS_W  = 17;
	localparam int unsigned CFGI_W  = 3;
	localparam int unsigned CFGD_W  = 17;

	typedef enum logic [1:0] {
		ERR_NONE        = 2'd0,
		ERR_CURRENT     = 2'd1,
		ERR_TEMPERATURE = 2'd2,
		ERR_COMM        = 2'd3
	} err_kind_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_ZERO = 2'd1,
		ACT_HOLD = 2'd2
	} action_t;

	typedef enum logic [CFGI_W-1:0] {
		CFG_CURRENT_LIMIT = 3'd0,
		CFG_REVERSE_FLOOR = 3'd1,
		CFG_TEMP_LIMIT    = 3'd2,
		CFG_PERSIST_LIMIT = 3'd3,
		CFG_COMM_TIMEOUT  = 3'd4
	} cfg_reg_t;

	localparam logic [CLIM_W-1:0]        RST_CURRENT_LIMIT = 15'd2500;
	localparam logic signed [CUR_W-1:0]  RST_REVERSE_FLOOR = -16'sd1000;
	localparam logic signed [TEMP_W-1:0] RST_TEMP_LIMIT    = 12'sd800;
	localparam logic [PERS_W-1:0]        RST_PERSIST_LIMIT = 8'd60;
	localparam logic [MISS_W-1:0]        RST_COMM_TIMEOUT  = 17'd100000;

	typedef struct packed {
		logic [PERS_W-1:0] cur_run;
		logic [PERS_W-1:0] temp_run;
		logic [MISS_W-1:0] miss_run;
	} run_entry_t;

endpackage

FILE: hdl/motor_fault_persistence_monitor_top.sv
// An accepted item is registered into stage 1, which reads its counter entry, then
// into the output registers, which offer its result until taken. Throughput: one
// item per cycle unless the output stalls; the per-motor counter memory is read at
// accept and written back as the item leaves stage 1, with same-motor forwarding.
// Reset clears the configuration to defaults, the latched error and the
// per-motor valid bits; a motor whose entry is not yet written reads as zero.
// Depends on mfpm_pkg.
module motor_fault_persistence_monitor_top
	import mfpm_pkg::*;
#(
	parameter int unsigned NUM_MOTORS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFGI_W-1:0]        cfg_index,
	input  logic [CFGD_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [IDX_W-1:0]         motor_index,
	input  logic signed [CUR_W-1:0]  motor_current,
	input  logic signed [TEMP_W-1:0] winding_temp,
	input  logic                     fresh_reply,
	input  logic signed [POS_W-1:0]  motor_position,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     fault,
	output logic [1:0]               error_kind,
	output logic [1:0]               safe_action,
	output logic signed [POS_W-1:0]  target_position
);

	localparam int unsigned ADDR_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

	logic [CLIM_W-1:0]        cur_limit_q;
	logic signed [CUR_W-1:0]  rev_floor_q;
	logic signed [TEMP_W-1:0] temp_limit_q;
	logic [PERS_W-1:0]        pers_limit_q;
	logic [MISS_W-1:0]        comm_timeout_q;

	run_entry_t               run_mem [NUM_MOTORS];
	logic [NUM_MOTORS-1:0]    valid_q;
	err_kind_t                latched_q;

	logic                     s1_valid;
	logic [ADDR_W-1:0]        addr_s1;
	logic                     in_range_s1;
	logic signed [CUR_W-1:0]  cur_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic                     fresh_s1;
	logic signed [POS_W-1:0]  pos_s1;
	run_entry_t               rd_s1;

	logic                     out_valid_q;
	logic                     fault_q;
	err_kind_t                err_q;
	action_t                  action_q;
	logic signed [POS_W-1:0]  target_q;

	logic                     in_accept;
	logic                     advance;
	logic                     s1_fire;
	logic                     wr_en;
	logic [ADDR_W-1:0]        rd_addr;
	logic                     in_range_in;

	logic                     cur_chk;
	logic signed [CUR_W:0]    cur_ext;
	logic [CUR_W:0]           cur_mag;
	logic                     cur_fault;
	logic                     comm_fault;
	logic                     temp_fault;
	run_entry_t               wr_data;
	err_kind_t                latched_nx;
	action_t                  action_nx;

	assign cfg_ready   = 1'b1;
	assign advance     = !out_valid_q || out_ready;
	assign in_ready    = !s1_valid || advance;
	assign in_accept   = in_valid && in_ready;
	assign s1_fire     = s1_valid && advance;
	assign wr_en       = s1_fire && in_range_s1;
	assign rd_addr     = ADDR_W'(motor_index);
	assign in_range_in = 32'(motor_index) < NUM_MOTORS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_limit_q    <= RST_CURRENT_LIMIT;
			rev_floor_q    <= RST_REVERSE_FLOOR;
			temp_limit_q   <= RST_TEMP_LIMIT;
			pers_limit_q   <= RST_PERSIST_LIMIT;
			comm_timeout_q <= RST_COMM_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CURRENT_LIMIT: cur_limit_q    <= cfg_data[CLIM_W-1:0];
				CFG_REVERSE_FLOOR: rev_floor_q    <= cfg_data[CUR_W-1:0];
				CFG_TEMP_LIMIT:    temp_limit_q   <= cfg_data[TEMP_W-1:0];
				CFG_PERSIST_LIMIT: pers_limit_q   <= cfg_data[PERS_W-1:0];
				CFG_COMM_TIMEOUT:  comm_timeout_q <= cfg_data[MISS_W-1:0];
				default: ;
			endcase
		end
	end

	// checks in order current, communication, temperature; stop at first fault
	always_comb begin
		wr_data    = rd_s1;
		cur_chk    = cur_s1 >= rev_floor_q;
		cur_ext    = {cur_s1[CUR_W-1], cur_s1};
		cur_mag    = cur_ext[CUR_W] ? (CUR_W+1)'(-cur_ext) : cur_ext;
		cur_fault  = 1'b0;
		comm_fault = 1'b0;
		temp_fault = 1'b0;
		if (cur_chk) begin
			if (cur_mag > {2'b00, cur_limit_q})
				wr_data.cur_run = (rd_s1.cur_run == '1) ? rd_s1.cur_run
					: PERS_W'(rd_s1.cur_run + 1'b1);
			else
				wr_data.cur_run = '0;
			cur_fault = wr_data.cur_run > pers_limit_q;
		end
		if (!cur_fault) begin
			if (fresh_s1)
				wr_data.miss_run = '0;
			else
				wr_data.miss_run = (rd_s1.miss_run == '1) ? rd_s1.miss_run
					: MISS_W'(rd_s1.miss_run + 1'b1);
			comm_fault = wr_data.miss_run > comm_timeout_q;
		end
		if (!cur_fault && !comm_fault) begin
			if (temp_s1 > temp_limit_q)
				wr_data.temp_run = (rd_s1.temp_run == '1) ? rd_s1.temp_run
					: PERS_W'(rd_s1.temp_run + 1'b1);
			else
				wr_data.temp_run = '0;
			temp_fault = wr_data.temp_run > pers_limit_q;
		end
		if (!in_range_s1) begin
			cur_fault  = 1'b0;
			comm_fault = 1'b0;
			temp_fault = 1'b0;
		end
	end

	always_comb begin
		latched_nx = latched_q;
		if (cur_fault)
			latched_nx = ERR_CURRENT;
		else if (comm_fault)
			latched_nx = ERR_COMM;
		else if (temp_fault)
			latched_nx = ERR_TEMPERATURE;
		case (latched_nx)
			ERR_CURRENT, ERR_TEMPERATURE: action_nx = ACT_ZERO;
			ERR_COMM:                     action_nx = ACT_HOLD;
			default:                      action_nx = ACT_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			run_mem[addr_s1] <= wr_data;
	end

	// read at accept; forward the entry being written back
	always_ff @(posedge clk) begin
		if (in_accept) begin
			addr_s1     <= rd_addr;
			in_range_s1 <= in_range_in;
			cur_s1      <= motor_current;
			temp_s1     <= winding_temp;
			fresh_s1    <= fresh_reply;
			pos_s1      <= motor_position;
			if (!in_range_in)
				rd_s1 <= '0;
			else if (wr_en && addr_s1 == rd_addr)
				rd_s1 <= wr_data;
			else if (valid_q[rd_addr])
				rd_s1 <= run_mem[rd_addr];
			else
				rd_s1 <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			latched_q   <= ERR_NONE;
		end else begin
			if (in_accept)
				s1_valid <= 1'b1;
			else if (s1_fire)
				s1_valid <= 1'b0;
			if (s1_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (wr_en)
				valid_q[addr_s1] <= 1'b1;
			if (s1_fire)
				latched_q <= latched_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			fault_q  <= cur_fault || comm_fault || temp_fault;
			err_q    <= latched_nx;
			action_q <= action_nx;
			target_q <= (action_nx == ACT_HOLD) ? pos_s1 : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign fault           = fault_q;
	assign error_kind      = err_q;
	assign safe_action     = action_q;
	assign target_position = target_q;

	a_fault_has_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> error_kind != ERR_NONE)
		else $error("fault reported without error kind");

	a_hold_on_comm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_kind == ERR_COMM |-> safe_action == ACT_HOLD)
		else $error("communication error without hold action");

	a_latch_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		latched_q != ERR_NONE |=> latched_q != ERR_NONE)
		else $error("latched error cleared");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without output stall");

endmodule
